FILE: design/pptu_pkg.sv
// pptu_pkg: types, codes and helpers shared by the pcm player transport unit
// depends on nothing; every other file of the block uses it by scoped names
package pptu_pkg;

	// largest track count the wrap logic honors (the 5-bit index caps it at 32)
	localparam int MAX_TRACKS = 32;
	localparam int QUEUE_DEPTH = 2;

	// active-low button patterns
	localparam logic [3:0] BTN_NEXT = 4'hE;
	localparam logic [3:0] BTN_PLAY = 4'hD;
	localparam logic [3:0] BTN_STOP = 4'hB;
	localparam logic [3:0] BTN_BACK = 4'h7;

	localparam logic REQ_BUTTON = 1'b0;
	localparam logic REQ_FRAME  = 1'b1;

	// transport codes as seen on the result beat
	localparam logic [1:0] XPORT_STOPPED = 2'd0;
	localparam logic [1:0] XPORT_PLAYING = 2'd1;
	localparam logic [1:0] XPORT_PAUSED  = 2'd2;

	typedef enum logic [2:0] {
		ST_STOPPED = 3'b001,
		ST_PLAYING = 3'b010,
		ST_PAUSED  = 3'b100
	} xport_state_t;

	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_HALF   = 2'd1,
		MODE_DOUBLE = 2'd2,
		MODE_MONO   = 2'd3
	} speed_mode_t;

	typedef struct packed {
		logic               req_type;
		logic [3:0]         button_pins;
		logic [1:0]         mode_switches;
		logic signed [15:0] left_in;
		logic signed [15:0] right_in;
		logic               frame_last;
	} req_t;

	typedef struct packed {
		logic               has_sample;
		logic signed [15:0] left_out;
		logic signed [15:0] right_out;
		logic [1:0]         transport;
		logic [4:0]         track_number;
		logic               restart_track;
		logic               frame_taken;
		logic               last_of_run;
	} rsp_t;

	// one queued command: the result beat and whether it goes out twice
	typedef struct packed {
		rsp_t beat;
		logic dup;
	} cmd_t;

	function automatic logic [1:0] xport_code(input xport_state_t st);
		logic [1:0] code;
		unique case (st)
			ST_PLAYING: code = XPORT_PLAYING;
			ST_PAUSED:  code = XPORT_PAUSED;
			default:    code = XPORT_STOPPED;
		endcase
		return code;
	endfunction

endpackage

FILE: design/pptu_front.sv
// pptu_front: accepts request beats, updates transport state, builds commands
// depends on pptu_pkg
module pptu_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [5:0]        cfg_wdata,
	input  logic              accept,
	input  pptu_pkg::req_t    req,
	output pptu_pkg::cmd_t    cmd
);

	localparam int CAP = (pptu_pkg::MAX_TRACKS < 32) ? pptu_pkg::MAX_TRACKS : 32;
	localparam logic [5:0] CAP6 = 6'(CAP);

	logic [5:0]             track_count_q;
	pptu_pkg::xport_state_t state_q, state_d;
	logic [4:0]             idx_q, idx_d;
	pptu_pkg::speed_mode_t  mode_q, mode_d;
	logic                   skip_q, skip_d;

	logic [5:0] n_eff;
	logic [5:0] idx_inc;
	logic [5:0] n_dec;
	logic signed [15:0] lo, ro;
	logic has, taken, restart, dup;

	always_comb begin
		if (track_count_q == 6'd0) begin
			n_eff = 6'd1;
		end else if (track_count_q > CAP6) begin
			n_eff = CAP6;
		end else begin
			n_eff = track_count_q;
		end
	end

	assign idx_inc = {1'b0, idx_q} + 6'd1;
	assign n_dec   = n_eff - 6'd1;

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		mode_d  = mode_q;
		skip_d  = skip_q;
		has     = 1'b0;
		taken   = 1'b0;
		restart = 1'b0;
		dup     = 1'b0;
		lo      = req.left_in;
		ro      = req.right_in;
		if (req.req_type == pptu_pkg::REQ_BUTTON) begin
			unique case (req.button_pins)
				pptu_pkg::BTN_NEXT, pptu_pkg::BTN_BACK: begin
					if (req.button_pins == pptu_pkg::BTN_NEXT) begin
						idx_d = (idx_inc >= n_eff) ? 5'd0 : idx_inc[4:0];
					end else begin
						idx_d = (idx_q == 5'd0 || {1'b0, idx_q} >= n_eff) ?
							n_dec[4:0] : idx_q - 5'd1;
					end
					if (state_q == pptu_pkg::ST_PLAYING) begin
						mode_d  = pptu_pkg::speed_mode_t'(req.mode_switches);
						restart = 1'b1;
					end else begin
						state_d = pptu_pkg::ST_STOPPED;
					end
					skip_d = 1'b0;
				end
				pptu_pkg::BTN_PLAY: begin
					if (state_q == pptu_pkg::ST_PLAYING) begin
						state_d = pptu_pkg::ST_PAUSED;
					end else begin
						// fresh start from stopped, not a resume
						if (state_q != pptu_pkg::ST_PAUSED) begin
							restart = 1'b1;
							skip_d  = 1'b0;
						end
						state_d = pptu_pkg::ST_PLAYING;
						mode_d  = pptu_pkg::speed_mode_t'(req.mode_switches);
					end
				end
				pptu_pkg::BTN_STOP: begin
					state_d = pptu_pkg::ST_STOPPED;
					skip_d  = 1'b0;
				end
				default: begin
				end
			endcase
		end else if (state_q == pptu_pkg::ST_PLAYING) begin
			taken = 1'b1;
			has   = 1'b1;
			unique case (mode_q)
				pptu_pkg::MODE_MONO:   lo = req.right_in;
				pptu_pkg::MODE_DOUBLE: begin
					has    = ~skip_q;
					skip_d = ~skip_q;
				end
				pptu_pkg::MODE_HALF:   dup = 1'b1;
				default: begin
				end
			endcase
			if (req.frame_last) begin
				state_d = pptu_pkg::ST_STOPPED;
				skip_d  = 1'b0;
			end
		end
	end

	always_comb begin
		cmd.dup                = dup;
		cmd.beat.has_sample    = has;
		cmd.beat.left_out      = has ? lo : 16'sd0;
		cmd.beat.right_out     = has ? ro : 16'sd0;
		cmd.beat.transport     = pptu_pkg::xport_code(state_d);
		cmd.beat.track_number  = idx_d;
		cmd.beat.restart_track = restart;
		cmd.beat.frame_taken   = taken;
		cmd.beat.last_of_run   = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_count_q <= 6'd1;
			state_q       <= pptu_pkg::ST_STOPPED;
			idx_q         <= 5'd0;
			mode_q        <= pptu_pkg::MODE_NORMAL;
			skip_q        <= 1'b0;
		end else begin
			if (cfg_we) begin
				track_count_q <= cfg_wdata;
			end
			if (accept) begin
				state_q <= state_d;
				idx_q   <= idx_d;
				mode_q  <= mode_d;
				skip_q  <= skip_d;
			end
		end
	end

endmodule

FILE: design/pptu_queue.sv
// pptu_queue: short command fifo between front and back
// depends on pptu_pkg
module pptu_queue #(
	parameter int DEPTH = pptu_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  pptu_pkg::cmd_t push_cmd,
	input  logic           pop,
	output logic           full,
	output logic           not_empty,
	output pptu_pkg::cmd_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

	pptu_pkg::cmd_t  mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full      = (count_q == DEPTH_C);
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

FILE: design/pptu_back.sv
// pptu_back: drains commands into result beats, repeating half-speed frames
// depends on pptu_pkg
module pptu_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  pptu_pkg::cmd_t q_head,
	output logic           q_pop,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output pptu_pkg::rsp_t rsp
);

	logic           valid_q;
	logic           rep_q;
	pptu_pkg::rsp_t beat_q;
	pptu_pkg::rsp_t load_beat;
	logic           advance;
	logic           repeat_now;

	assign advance    = !valid_q || !rsp_stall;
	assign repeat_now = valid_q && rep_q;
	assign q_pop      = advance && !repeat_now && q_valid;
	assign rsp_valid  = valid_q;
	assign rsp        = beat_q;

	// first beat of a repeated frame is not the closing one
	always_comb begin
		load_beat             = q_head.beat;
		load_beat.last_of_run = !q_head.dup;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (repeat_now) begin
				beat_q.last_of_run <= 1'b1;
			end else if (q_valid) begin
				beat_q <= load_beat;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rep_q   <= 1'b0;
		end else if (advance) begin
			if (repeat_now) begin
				rep_q <= 1'b0;
			end else begin
				valid_q <= q_valid;
				rep_q   <= q_valid && q_head.dup;
			end
		end
	end

endmodule

FILE: design/pcm_player_transport_unit.sv
// pcm_player_transport_unit: a request beat passes the queue, then the result register
// throughput one request per cycle while the queue has room; a half-speed frame adds a closing beat
// the single result register, one beat per cycle unless rsp_stall holds it, sets that figure
// arst_n clears transport to stopped, track 0, normal speed, track_count 1 and the queue
// depends on pptu_pkg, pptu_front, pptu_queue, pptu_back
module pcm_player_transport_unit #(
	parameter int QUEUE_DEPTH = pptu_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	// track count register
	input  logic           cfg_we,
	input  logic [5:0]     cfg_wdata,
	// request channel
	input  logic           req_valid,
	output logic           req_stall,
	input  pptu_pkg::req_t req,
	// result channel
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output pptu_pkg::rsp_t rsp
);

	logic           accept;
	logic           q_full;
	logic           q_valid;
	logic           q_pop;
	pptu_pkg::cmd_t front_cmd;
	pptu_pkg::cmd_t q_head;

	// the front only waits for room in the queue, never for the result side
	assign req_stall = q_full;
	assign accept    = req_valid && !q_full;

	// front: classify the beat and advance transport state in the same cycle
	pptu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.req       (req),
		.cmd       (front_cmd)
	);

	// queue decouples the two stall domains
	pptu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_cmd  (front_cmd),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_valid),
		.head      (q_head)
	);

	// back: one or two result beats per command
	pptu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// the first beat of a repeated frame is followed by its closing beat with the same has_sample and left_out
	a_repeat_follows: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_stall && !rsp.last_of_run |=>
			rsp_valid && rsp.last_of_run && rsp.has_sample == $past(rsp.has_sample)
			&& rsp.left_out == $past(rsp.left_out))
		else $error("repeat beat missing or altered");

	// a beat without a sample carries zero samples
	a_silent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.has_sample |-> rsp.left_out == 16'sd0 && rsp.right_out == 16'sd0)
		else $error("samples set on silent beat");

	// a restart request only comes with playing transport
	a_restart_playing: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.restart_track |-> rsp.transport == pptu_pkg::XPORT_PLAYING)
		else $error("restart while not playing");

	// a refused frame never yields a sample
	a_refused_silent: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.frame_taken |-> !rsp.has_sample)
		else $error("sample without consumed frame");

endmodule
